// ----- src/tsd_pkg.sv -----
`default_nettype none
package tsd_pkg;

  // Coordinate width after the center subtraction and three turns.
  localparam int COORD_W   = 40;
  localparam int TURN_W    = 16;
  localparam int TURN_FRAC = 14;
  localparam int ROOT_W    = 40;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int HALF_W    = COORD_W / 2;
  // Absolute value, partial products, sum of squares, then one stage per root bit.
  localparam int MAG_LAT   = 3 + ROOT_W;

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_MAJOR     = 3'd3,
    REG_MINOR     = 3'd4,
    REG_X_SINCOS  = 3'd5,
    REG_Y_SINCOS  = 3'd6,
    REG_Z_SINCOS  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic en;
    logic valid;
  } tsd_ctl_t;

endpackage
`default_nettype wire

// ----- src/torus_signed_distance_core.sv -----
// Channel   Handshake                 Payload
// input     in_valid / in_stall       point_x, point_y, point_z
// output    out_valid / out_stall     signed_distance
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One point enters per cycle while the output is not stalled; each result passes
// center subtraction, three two-stage turns, two 43-stage magnitude pipelines
// with the major radius stage between them, and the output register.
// Reset is synchronous and clears all valid bits and loads the register defaults.
// The whole pipeline holds while a result waits under out_stall.
`default_nettype none
module torus_signed_distance_core
  import tsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      signed_distance,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic [31:0] center_x, center_y, center_z;
  logic [30:0] major_radius, minor_radius;
  logic [31:0] x_turn_sincos, y_turn_sincos, z_turn_sincos;

  logic     adv;
  tsd_ctl_t ctl_in, ctl_x, ctl_y, ctl_z, ctl_d;

  logic                      s0_valid;
  logic signed [COORD_W-1:0] s0_x, s0_y, s0_z;
  logic                      vx, vy, vz;
  logic signed [COORD_W-1:0] ax_y, ax_z, ax_x;
  logic signed [COORD_W-1:0] ay_z, ay_x, ay_y;
  logic signed [COORD_W-1:0] az_x, az_y, az_z;
  logic                      m1_valid, m2_valid;
  logic [ROOT_W-1:0]         root1, root2;
  logic [COORD_W-1:0]        y_late;
  logic                      d_valid;
  logic signed [COORD_W-1:0] d_reg, y_reg;
  logic signed [ROOT_W:0]    tube_gap;

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      major_radius  <= 31'd65536;
      minor_radius  <= 31'd16384;
      x_turn_sincos <= 32'd16384;
      y_turn_sincos <= 32'd16384;
      z_turn_sincos <= 32'd16384;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: center_x      <= cfg_data;
        REG_CENTER_Y: center_y      <= cfg_data;
        REG_CENTER_Z: center_z      <= cfg_data;
        REG_MAJOR:    major_radius  <= cfg_data[30:0];
        REG_MINOR:    minor_radius  <= cfg_data[30:0];
        REG_X_SINCOS: x_turn_sincos <= cfg_data;
        REG_Y_SINCOS: y_turn_sincos <= cfg_data;
        REG_Z_SINCOS: z_turn_sincos <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      d_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_valid  <= in_valid;
      d_valid   <= m1_valid;
      out_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x <= {{(COORD_W-32){point_x[31]}}, point_x}
            - {{(COORD_W-32){center_x[31]}}, center_x};
      s0_y <= {{(COORD_W-32){point_y[31]}}, point_y}
            - {{(COORD_W-32){center_y[31]}}, center_y};
      s0_z <= {{(COORD_W-32){point_z[31]}}, point_z}
            - {{(COORD_W-32){center_z[31]}}, center_z};
    end
  end

  assign ctl_in = '{en: adv, valid: s0_valid};
  assign ctl_x  = '{en: adv, valid: vx};
  assign ctl_y  = '{en: adv, valid: vy};
  assign ctl_z  = '{en: adv, valid: vz};
  assign ctl_d  = '{en: adv, valid: d_valid};

  tsd_rotate u_turn_x (
    .clk(clk), .rst(rst), .ctl(ctl_in), .sincos(x_turn_sincos),
    .a(s0_y), .b(s0_z), .c(s0_x),
    .valid(vx), .a_rot(ax_y), .b_rot(ax_z), .c_pass(ax_x)
  );

  tsd_rotate u_turn_y (
    .clk(clk), .rst(rst), .ctl(ctl_x), .sincos(y_turn_sincos),
    .a(ax_z), .b(ax_x), .c(ax_y),
    .valid(vy), .a_rot(ay_z), .b_rot(ay_x), .c_pass(ay_y)
  );

  tsd_rotate u_turn_z (
    .clk(clk), .rst(rst), .ctl(ctl_y), .sincos(z_turn_sincos),
    .a(ay_x), .b(ay_y), .c(ay_z),
    .valid(vz), .a_rot(az_x), .b_rot(az_y), .c_pass(az_z)
  );

  tsd_mag u_ring (
    .clk(clk), .rst(rst), .ctl(ctl_z), .a(az_x), .b(az_z),
    .valid(m1_valid), .root(root1)
  );

  tsd_delay #(.W(COORD_W), .DEPTH(MAG_LAT)) u_y_line (
    .clk(clk), .en(adv), .d(az_y), .q(y_late)
  );

  // The ring distance never exceeds the coordinate range, so the wrap is exact.
  always_ff @(posedge clk) begin
    if (adv) begin
      d_reg <= COORD_W'(root1 - {{(ROOT_W-31){1'b0}}, major_radius});
      y_reg <= y_late;
    end
  end

  tsd_mag u_tube (
    .clk(clk), .rst(rst), .ctl(ctl_d), .a(d_reg), .b(y_reg),
    .valid(m2_valid), .root(root2)
  );

  assign tube_gap = {1'b0, root2} - {{(ROOT_W-30){1'b0}}, minor_radius};

  // The result can only overflow upward; the root is never negative.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (tube_gap > (ROOT_W+1)'(32'sh7FFF_FFFF)) begin
        signed_distance <= 32'sh7FFF_FFFF;
      end else begin
        signed_distance <= tube_gap[31:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/tsd_rotate.sv -----
`default_nettype none
module tsd_rotate
  import tsd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire tsd_ctl_t                  ctl,
  input  wire logic [2*TURN_W-1:0]       sincos,
  input  wire logic signed [COORD_W-1:0] a,
  input  wire logic signed [COORD_W-1:0] b,
  input  wire logic signed [COORD_W-1:0] c,
  output logic                           valid,
  output logic signed [COORD_W-1:0]      a_rot,
  output logic signed [COORD_W-1:0]      b_rot,
  output logic signed [COORD_W-1:0]      c_pass
);

  localparam int PROD_W = COORD_W + TURN_W;

  logic signed [TURN_W-1:0] cs;
  logic signed [TURN_W-1:0] sn;
  logic signed [PROD_W-1:0] p_ca, p_sb, p_sa, p_cb;
  logic signed [COORD_W-1:0] c_mid;
  logic                      valid_mid;
  logic signed [PROD_W:0]   sum_a, sum_b;

  assign cs = sincos[TURN_W-1:0];
  assign sn = sincos[2*TURN_W-1:TURN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_mid <= 1'b0;
      valid     <= 1'b0;
    end else if (ctl.en) begin
      valid_mid <= ctl.valid;
      valid     <= valid_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p_ca  <= cs * a;
      p_sb  <= sn * b;
      p_sa  <= sn * a;
      p_cb  <= cs * b;
      c_mid <= c;
    end
  end

  // Round half up, then an arithmetic shift back to the coordinate format.
  always_comb begin
    sum_a = PROD_W'(p_ca) - p_sb + (PROD_W + 1)'(1 <<< (TURN_FRAC - 1));
    sum_b = PROD_W'(p_sa) + p_cb + (PROD_W + 1)'(1 <<< (TURN_FRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      a_rot  <= sum_a[TURN_FRAC+COORD_W-1:TURN_FRAC];
      b_rot  <= sum_b[TURN_FRAC+COORD_W-1:TURN_FRAC];
      c_pass <= c_mid;
    end
  end

endmodule
`default_nettype wire

// ----- src/tsd_delay.sv -----
`default_nettype none
module tsd_delay
  import tsd_pkg::*;
#(
  parameter int W     = COORD_W,
  parameter int DEPTH = MAG_LAT
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic [W-1:0]      q
);

  logic [W-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        tap[k] <= tap[k-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule
`default_nettype wire

// ----- src/tsd_mag.sv -----
`default_nettype none
module tsd_mag
  import tsd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire tsd_ctl_t                  ctl,
  input  wire logic signed [COORD_W-1:0] a,
  input  wire logic signed [COORD_W-1:0] b,
  output logic                           valid,
  output logic [ROOT_W-1:0]              root
);

  logic [COORD_W-1:0]  abs_a, abs_b;
  logic                v_abs, v_prod;
  logic [2*HALF_W-1:0] a_hh, a_hl, a_ll, b_hh, b_hl, b_ll;
  logic [RAD_W-1:0]    sq_sum;

  logic               sv   [ROOT_W+1];
  logic [REM_W-1:0]   rem  [ROOT_W+1];
  logic [ROOT_W-1:0]  rt   [ROOT_W+1];
  logic [RAD_W-1:0]   rad  [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_abs  <= 1'b0;
      v_prod <= 1'b0;
      sv[0]  <= 1'b0;
    end else if (ctl.en) begin
      v_abs  <= ctl.valid;
      v_prod <= v_abs;
      sv[0]  <= v_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      abs_a <= a[COORD_W-1] ? COORD_W'(-a) : COORD_W'(a);
      abs_b <= b[COORD_W-1] ? COORD_W'(-b) : COORD_W'(b);
      a_hh  <= abs_a[COORD_W-1:HALF_W] * abs_a[COORD_W-1:HALF_W];
      a_hl  <= abs_a[COORD_W-1:HALF_W] * abs_a[HALF_W-1:0];
      a_ll  <= abs_a[HALF_W-1:0] * abs_a[HALF_W-1:0];
      b_hh  <= abs_b[COORD_W-1:HALF_W] * abs_b[COORD_W-1:HALF_W];
      b_hl  <= abs_b[COORD_W-1:HALF_W] * abs_b[HALF_W-1:0];
      b_ll  <= abs_b[HALF_W-1:0] * abs_b[HALF_W-1:0];
    end
  end

  // The sum of both squares always fits in the radicand width.
  assign sq_sum = ({a_hh, {(2*HALF_W){1'b0}}} + RAD_W'({a_hl, {(HALF_W+1){1'b0}}})
                   + RAD_W'(a_ll))
                + ({b_hh, {(2*HALF_W){1'b0}}} + RAD_W'({b_hl, {(HALF_W+1){1'b0}}})
                   + RAD_W'(b_ll));

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem[0] <= '0;
      rt[0]  <= '0;
      rad[0] <= sq_sum;
    end
  end

  // Restoring square root, one result bit per stage, two radicand bits consumed each.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    logic [REM_W+1:0] r4;
    logic [REM_W+1:0] trial;
    logic             ge;

    assign r4    = {rem[k], rad[k][RAD_W-1 -: 2]};
    assign trial = {2'b00, rt[k], 2'b01};
    assign ge    = (r4 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (ctl.en) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem[k+1] <= ge ? REM_W'(r4 - trial) : REM_W'(r4);
        rt[k+1]  <= {rt[k][ROOT_W-2:0], ge};
        rad[k+1] <= {rad[k][RAD_W-3:0], 2'b00};
      end
    end
  end

  assign valid = sv[ROOT_W];
  assign root  = rt[ROOT_W];

endmodule
`default_nettype wire

// ----- src/tsd_check.sv -----
`default_nettype none
module tsd_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] signed_distance,
  input wire logic        cfg_ready
);

  // Input is held back only while a finished word is blocked at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked output word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(signed_distance)))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> cfg_ready)
    else $error("configuration port not ready");

endmodule

bind torus_signed_distance_core tsd_check u_tsd_check (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .signed_distance(signed_distance), .cfg_ready(cfg_ready)
);
`default_nettype wire

// ----- test/torus_signed_distance_core_test.sv -----
`default_nettype none
module torus_signed_distance_core_test
  import tsd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HANG_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 200;
  localparam int NUM_RANDOM  = 400;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } point_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] signed_distance;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  torus_signed_distance_core u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .signed_distance(signed_distance),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the block's registers, indexed by register code.
  logic [31:0] torus_regs [8];

  point_t point_q[$];
  logic signed [31:0] distance_q[$];

  int fail_cnt;
  int idle_cycles;
  bit point_taken;
  bit quiet_mode;
  int in_gap;
  int out_gap;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Rotation with round half up back to the coordinate's scale.
  function automatic void rotate_pair(inout longint a, inout longint b, input logic [31:0] sc);
    longint c;
    longint s;
    longint na;
    longint nb;
    c = longint'($signed(sc[15:0]));
    s = longint'($signed(sc[31:16]));
    na = (c * a - s * b + 64'sd8192) >>> TURN_FRAC;
    nb = (s * a + c * b + 64'sd8192) >>> TURN_FRAC;
    a = na;
    b = nb;
  endfunction

  function automatic longint hypot_floor(longint a, longint b);
    logic [127:0] ua;
    logic [127:0] ub;
    logic [127:0] sum_sq;
    logic [127:0] trial;
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    sum_sq = ua * ua + ub * ub;
    trial = '0;
    for (int bit_i = 39; bit_i >= 0; bit_i--) begin
      if (((trial | (128'd1 << bit_i)) * (trial | (128'd1 << bit_i))) <= sum_sq) begin
        trial = trial | (128'd1 << bit_i);
      end
    end
    return longint'(trial);
  endfunction

  function automatic logic signed [31:0] torus_distance(point_t p);
    longint x;
    longint y;
    longint z;
    longint ring;
    longint sd_val;
    x = longint'(p.px) - longint'($signed(torus_regs[REG_CENTER_X]));
    y = longint'(p.py) - longint'($signed(torus_regs[REG_CENTER_Y]));
    z = longint'(p.pz) - longint'($signed(torus_regs[REG_CENTER_Z]));
    rotate_pair(y, z, torus_regs[REG_X_SINCOS]);
    rotate_pair(z, x, torus_regs[REG_Y_SINCOS]);
    rotate_pair(x, y, torus_regs[REG_Z_SINCOS]);
    ring = hypot_floor(x, z) - longint'(torus_regs[REG_MAJOR]);
    sd_val = hypot_floor(ring, y) - longint'(torus_regs[REG_MINOR]);
    if (sd_val > 64'sd2147483647) sd_val = 64'sd2147483647;
    if (sd_val < -64'sd2147483648) sd_val = -64'sd2147483648;
    return sd_val[31:0];
  endfunction

  // Monitor: prediction on input acceptance, checking on output acceptance.
  always @(posedge clk) begin
    bit busy;
    if (!rst) begin
      busy = 1'b0;
      if (in_valid && !in_stall) begin
        point_t p;
        p.px = point_x;
        p.py = point_y;
        p.pz = point_z;
        distance_q.push_back(torus_distance(p));
        point_taken = 1'b1;
        busy = 1'b1;
      end
      if (cfg_valid && cfg_ready) busy = 1'b1;
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (distance_q.size() == 0) begin
          $error("unexpected word: signed_distance actual %0d", signed_distance);
          fail_cnt++;
        end else begin
          logic signed [31:0] want;
          want = distance_q.pop_front();
          if (signed_distance !== want) begin
            $error("signed_distance mismatch: expected %0d actual %0d", want, signed_distance);
            fail_cnt++;
          end
        end
      end
      idle_cycles <= busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("** torus_signed_distance_core: FAILED **");
        $finish;
      end
    end
  end

  // Input driver: the payload only moves once the current word is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || point_taken) begin
      point_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (point_q.size() > 0) begin
        point_t p;
        p = point_q.pop_front();
        point_x <= p.px;
        point_y <= p.py;
        point_z <= p.pz;
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      out_gap <= pick_gap();
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // Radii are 31 bits wide; the top data bit is dropped.
    if (idx == REG_MAJOR || idx == REG_MINOR) torus_regs[idx] = {1'b0, value[30:0]};
    else torus_regs[idx] = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (point_q.size() > 0 || in_valid || distance_q.size() > 0) @(posedge clk);
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.px = x;
    p.py = y;
    p.pz = z;
    point_q.push_back(p);
  endtask

  function automatic logic [31:0] near_coord();
    return $urandom_range(0, 1) ? 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000)
                                : $urandom();
  endfunction

  function automatic logic [31:0] rand_sincos();
    int r;
    r = $urandom_range(9);
    if (r == 0) return {16'h8000, 16'h8000};
    if (r == 1) return {16'h7FFF, 16'h7FFF};
    if (r < 5) return {16'(5793), 16'(5793)} ^ {$urandom_range(1) ? 16'h0000 : 16'hFFFF, 16'h0};
    return $urandom();
  endfunction

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_CENTER_X;
    cfg_data = '0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    fail_cnt = 0;
    idle_cycles = 0;
    point_taken = 1'b0;
    quiet_mode = 1'b0;
    in_gap = 0;
    out_gap = 0;
    torus_regs[REG_CENTER_X] = 32'd0;
    torus_regs[REG_CENTER_Y] = 32'd0;
    torus_regs[REG_CENTER_Z] = 32'd0;
    torus_regs[REG_MAJOR] = 32'd65536;
    torus_regs[REG_MINOR] = 32'd16384;
    torus_regs[REG_X_SINCOS] = 32'd16384;
    torus_regs[REG_Y_SINCOS] = 32'd16384;
    torus_regs[REG_Z_SINCOS] = 32'd16384;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset defaults: origin, on the ring, far corners that saturate.
    add_point(32'h0, 32'h0, 32'h0);
    add_point(32'h0001_0000, 32'h0, 32'h0);
    add_point(32'h0, 32'h0000_4000, 32'h0001_0000);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    add_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000);
    wait_drained();

    // Extreme registers: far centers, widest radii with the dropped top bit,
    // and non-unit coefficients at both ends of the range.
    write_reg(REG_CENTER_X, 32'h8000_0000);
    write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
    write_reg(REG_CENTER_Z, 32'h8000_0000);
    write_reg(REG_MAJOR, 32'hFFFF_FFFF);
    write_reg(REG_MINOR, 32'hFFFF_FFFF);
    write_reg(REG_X_SINCOS, 32'h8000_8000);
    write_reg(REG_Y_SINCOS, 32'h7FFF_7FFF);
    write_reg(REG_Z_SINCOS, 32'h8000_7FFF);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_point(32'h0, 32'h0, 32'h0);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    wait_drained();

    // Zero radii, zero X coefficients and quarter turns about Y and Z reduce each point to |x|.
    write_reg(REG_MAJOR, 32'h0);
    write_reg(REG_MINOR, 32'h0);
    write_reg(REG_X_SINCOS, 32'h0);
    write_reg(REG_Y_SINCOS, 32'h4000_0000);
    write_reg(REG_Z_SINCOS, 32'hC000_0000);
    write_reg(REG_CENTER_X, 32'h0);
    write_reg(REG_CENTER_Y, 32'h0);
    write_reg(REG_CENTER_Z, 32'h0);
    add_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_point(32'h0, 32'h0, 32'h0);
    wait_drained();

    // Random phases, each with a fresh register set.
    for (int phase = 0; phase < 8; phase++) begin
      quiet_mode = (phase % 3 == 1);
      write_reg(REG_CENTER_X, (phase == 7) ? 32'h7FFF_FFFF : near_coord());
      write_reg(REG_CENTER_Y, (phase == 7) ? 32'h8000_0000 : near_coord());
      write_reg(REG_CENTER_Z, near_coord());
      write_reg(REG_MAJOR, $urandom_range(1) ? $urandom_range(0, 32'h0004_0000) : $urandom());
      write_reg(REG_MINOR, $urandom_range(1) ? $urandom_range(0, 32'h0002_0000) : $urandom());
      write_reg(REG_X_SINCOS, rand_sincos());
      write_reg(REG_Y_SINCOS, rand_sincos());
      write_reg(REG_Z_SINCOS, rand_sincos());
      for (int n = 0; n < NUM_RANDOM / 8; n++) begin
        add_point(near_coord(), near_coord(), near_coord());
      end
      wait_drained();
    end
    quiet_mode = 1'b0;

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0 && distance_q.size() == 0) begin
      $display("** torus_signed_distance_core: PASSED **");
    end else begin
      $display("** torus_signed_distance_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- torus_signed_distance_core.f -----
src/tsd_pkg.sv
src/tsd_rotate.sv
src/tsd_delay.sv
src/tsd_mag.sv
src/torus_signed_distance_core.sv
src/tsd_check.sv
test/torus_signed_distance_core_test.sv
